@@ hw/rtl/vdbs_pkg.sv @@
// vdbs_pkg: shared constants and types for the voltage digit blink sequencer.
// No dependencies; imported by every module of the block.
package vdbs_pkg;

	// Serial divider geometry
	localparam int unsigned DIVD_W = 14;   // dividend / quotient width
	localparam int unsigned DIVS_W = 10;   // divisor / remainder width
	localparam int unsigned STEP_W = 4;    // step counter, holds DIVD_W

	// 1023 * 1.1 * 10, full-scale reading in tenths of a volt
	localparam logic [DIVD_W-1:0] FULL_SCALE_X10 = 14'd11253;
	// Largest value the digit widths hold, 255.9 V in tenths
	localparam logic [DIVD_W-1:0] MAX_X10        = 14'd2559;
	localparam logic [DIVS_W-1:0] DECIMAL_BASE   = 10'd10;

	// Reset values
	localparam logic [7:0] POINT_PAUSE_RST = 8'd2;
	localparam logic [7:0] GROUP_WAIT_RST  = 8'd20;
	localparam logic [7:0] VOLTS_RST       = 8'd1;
	localparam logic [3:0] TENTHS_RST      = 4'd0;

	// Item kinds
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_ADC  = 1'b1;

	// Config register indexes (paddr[2])
	localparam logic REG_POINT_PAUSE = 1'b0;
	localparam logic REG_GROUP_WAIT  = 1'b1;

	// Commit strobes from the control FSM to the sequencer
	typedef struct packed {
		logic tick;   // advance one display tick
		logic load;   // take new volts / tenths digits
	} seq_ctl_t;

endpackage

@@ hw/rtl/vdbs_div.sv @@
// vdbs_div: restoring divider, one quotient bit per cycle.
// Depends on vdbs_pkg.
module vdbs_div
	import vdbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [DIVD_W-1:0] quotient,
	output logic [DIVS_W-1:0] remainder
);

	logic [DIVD_W-1:0] shift_q;    // dividend bits out at top, quotient bits in at bottom
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [DIVS_W:0]   trial;
	logic              fits;
	logic [DIVS_W:0]   diff;

	assign trial = {rem_q, shift_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEP_W'(DIVD_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			dvs_q   <= divisor;
		end else if (cnt_q != '0) begin
			shift_q <= {shift_q[DIVD_W-2:0], fits};
			rem_q   <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = shift_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/vdbs_seq.sv @@
// vdbs_seq: four-phase blink sequencer and the held volts / tenths digits.
// Depends on vdbs_pkg.
module vdbs_seq
	import vdbs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  seq_ctl_t   ctl,
	input  logic [7:0] volts_in,
	input  logic [3:0] tenths_in,
	input  logic [7:0] point_pause,
	input  logic [7:0] group_wait,
	output logic       led,
	output logic       conv,
	output logic [7:0] volts,
	output logic [3:0] tenths
);

	localparam logic [1:0] PH_VOLTS  = 2'd0;
	localparam logic [1:0] PH_POINT  = 2'd1;
	localparam logic [1:0] PH_TENTHS = 2'd2;
	localparam logic [1:0] PH_WAIT   = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [7:0] cnt_q, cnt_d, cnt_m1;
	logic [7:0] volts_q;
	logic [3:0] tenths_q;

	assign cnt_m1 = cnt_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_m1;
		led     = 1'b0;
		conv    = 1'b0;
		unique case (phase_q)
			PH_VOLTS: begin
				led = 1'b1;
				if (cnt_m1 == 8'd0) begin
					phase_d = PH_POINT;
					cnt_d   = point_pause;
				end
			end
			PH_POINT: begin
				if (cnt_m1 == 8'd0) begin
					if (tenths_q == 4'd0) begin
						phase_d = PH_WAIT;
						cnt_d   = group_wait;
					end else begin
						phase_d = PH_TENTHS;
						cnt_d   = {4'd0, tenths_q};
					end
				end
			end
			PH_TENTHS: begin
				led = 1'b1;
				if (cnt_m1 == 8'd0) begin
					phase_d = PH_WAIT;
					cnt_d   = group_wait;
				end
			end
			PH_WAIT: begin
				if (cnt_m1 == 8'd0) begin
					phase_d = PH_VOLTS;
					cnt_d   = volts_q;
				end
				// request checked after a possible reload
				conv = (cnt_d == 8'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			cnt_q    <= GROUP_WAIT_RST;
			volts_q  <= VOLTS_RST;
			tenths_q <= TENTHS_RST;
		end else begin
			if (ctl.tick) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
			end
			if (ctl.load) begin
				volts_q  <= volts_in;
				tenths_q <= tenths_in;
			end
		end
	end

	assign volts  = volts_q;
	assign tenths = tenths_q;

endmodule

@@ hw/rtl/voltage_digit_blink_sequencer.sv @@
// voltage_digit_blink_sequencer: top level; control FSM, APB registers, output beat register.
// Depends on vdbs_pkg, vdbs_div, vdbs_seq.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | in_valid / in_stall       | mode, adc_value
//  output   | out_valid / out_stall     | led_pulse, start_conversion, volts_shown,
//           |                           | tenths_shown, reading_saturated
//  config   | psel/penable/pwrite/pready| paddr[2] selects register, pwdata[7:0]
//
// One item at a time. A tick beat goes from IDLE through WORK into the output register;
// an ADC beat goes through two passes of the shared one-bit divider (11253 / adc, then / 10),
// a digit capture at the end of DIVB and the output load from FIN.
// Reset puts the sequencer in the inter-group wait, counter 20, digits 1.0, registers 2/20.
// in_stall is high while an item is in flight; a result blocked by out_stall holds the
// FSM in WORK or FIN, but once it has moved on a new beat can already be taken.
module voltage_digit_blink_sequencer
	import vdbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [9:0]  adc_value,
	// output beats
	output logic        out_valid,
	input  logic        out_stall,
	output logic        led_pulse,
	output logic        start_conversion,
	output logic [7:0]  volts_shown,
	output logic [3:0]  tenths_shown,
	output logic        reading_saturated,
	// APB config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;  // ready for a beat
	localparam logic [2:0] ST_WORK = 3'd1;  // beat held, dispatch on mode
	localparam logic [2:0] ST_DIVA = 3'd2;  // 11253 / adc running
	localparam logic [2:0] ST_DIVB = 3'd3;  // x10 / 10 running
	localparam logic [2:0] ST_FIN  = 3'd4;  // digits ready, wait for output slot

	logic [2:0]  state_q;
	logic        mode_q;
	logic [9:0]  adc_q;
	logic        sat_q;
	logic [7:0]  volts_new_q;
	logic [3:0]  tenths_new_q;
	logic [7:0]  point_pause_q;
	logic [7:0]  group_wait_q;

	logic        out_valid_q;
	logic        led_q, conv_q, satout_q;
	logic [7:0]  volts_out_q;
	logic [3:0]  tenths_out_q;

	logic        accept;
	logic        out_free;
	logic        cfg_wr;

	// divider hookup
	logic              div_start;
	logic [DIVD_W-1:0] div_dividend;
	logic [DIVS_W-1:0] div_divisor;
	logic              div_done;
	logic [DIVD_W-1:0] div_quo;
	logic [DIVS_W-1:0] div_rem;

	// first-pass result checks
	logic              sat_now;
	logic [DIVD_W-1:0] x10;

	// sequencer hookup
	seq_ctl_t    seq_ctl;
	logic        seq_led, seq_conv;
	logic [7:0]  seq_volts;
	logic [3:0]  seq_tenths;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = ~out_valid_q | ~out_stall;
	assign cfg_wr   = psel & penable & pwrite & pready;

	// zero reading or quotient past 255.9 V clamps
	assign sat_now = (adc_q == 10'd0) || (div_quo > MAX_X10);
	assign x10     = sat_now ? MAX_X10 : div_quo;

	always_comb begin
		div_start    = 1'b0;
		div_dividend = FULL_SCALE_X10;
		div_divisor  = adc_q;
		if (state_q == ST_WORK && mode_q == MODE_ADC) begin
			div_start = 1'b1;
		end else if (state_q == ST_DIVA && div_done) begin
			div_start    = 1'b1;
			div_dividend = x10;
			div_divisor  = DECIMAL_BASE;
		end
	end

	// commit strobes: a tick steps the sequencer, an ADC result reloads digits
	always_comb begin
		seq_ctl.tick = (state_q == ST_WORK) && (mode_q == MODE_TICK) && out_free;
		seq_ctl.load = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_WORK;
				ST_WORK: begin
					if (mode_q == MODE_ADC) state_q <= ST_DIVA;
					else if (out_free)      state_q <= ST_IDLE;
				end
				ST_DIVA: if (div_done) state_q <= ST_DIVB;
				ST_DIVB: if (div_done) state_q <= ST_FIN;
				ST_FIN:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item and intermediate payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			adc_q  <= adc_value;
		end
		if (state_q == ST_DIVA && div_done) sat_q <= sat_now;
		if (state_q == ST_DIVB && div_done) begin
			volts_new_q  <= div_quo[7:0];
			tenths_new_q <= div_rem[3:0];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_pause_q <= POINT_PAUSE_RST;
			group_wait_q  <= GROUP_WAIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_POINT_PAUSE: point_pause_q <= pwdata[7:0];
				REG_GROUP_WAIT:  group_wait_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = {24'd0, (paddr[2] == REG_GROUP_WAIT) ? group_wait_q : point_pause_q};

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ctl.tick || seq_ctl.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ctl.tick) begin
			led_q        <= seq_led;
			conv_q       <= seq_conv;
			volts_out_q  <= seq_volts;
			tenths_out_q <= seq_tenths;
			satout_q     <= 1'b0;
		end else if (seq_ctl.load) begin
			led_q        <= 1'b0;
			conv_q       <= 1'b0;
			volts_out_q  <= volts_new_q;
			tenths_out_q <= tenths_new_q;
			satout_q     <= sat_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign led_pulse         = led_q;
	assign start_conversion  = conv_q;
	assign volts_shown       = volts_out_q;
	assign tenths_shown      = tenths_out_q;
	assign reading_saturated = satout_q;

	vdbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	vdbs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (seq_ctl),
		.volts_in    (volts_new_q),
		.tenths_in   (tenths_new_q),
		.point_pause (point_pause_q),
		.group_wait  (group_wait_q),
		.led         (seq_led),
		.conv        (seq_conv),
		.volts       (seq_volts),
		.tenths      (seq_tenths)
	);

endmodule
